>>> design/pidaw_pkg.sv
// pidaw_pkg: shared types, register indexes and saturation helpers for the
// anti-windup pid regulator; no dependencies

package pidaw_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 24;
  localparam int unsigned AccW   = 47;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [DataW-1:0]   q_t;
  typedef logic signed [DataW+1:0]   qsum_t;
  typedef logic signed [2*DataW-1:0] qprod_t;
  typedef logic [AccW-1:0]           acc_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_KP    = 3'd0;
  localparam cfg_idx_t CFG_KI    = 3'd1;
  localparam cfg_idx_t CFG_KD_C1 = 3'd2;
  localparam cfg_idx_t CFG_KR    = 3'd3;
  localparam cfg_idx_t CFG_KM    = 3'd4;
  localparam cfg_idx_t CFG_C2    = 3'd5;
  localparam cfg_idx_t CFG_UMAX  = 3'd6;
  localparam cfg_idx_t CFG_UMIN  = 3'd7;

  localparam q_t Q_MAX = {1'b0, {(DataW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DataW-1){1'b0}}};
  localparam q_t Q_ONE = q_t'(1) <<< FracW;

  // sign extension into the exact sum width
  function automatic qsum_t ext_sum(input q_t x);
    ext_sum = {{2{x[DataW-1]}}, x};
  endfunction

  // saturate an exact sum of up to three terms to 32 bits
  function automatic q_t sat_sum(input qsum_t s);
    if (s[DataW+1:DataW-1] == 3'b000 || s[DataW+1:DataW-1] == 3'b111) begin
      sat_sum = s[DataW-1:0];
    end else begin
      sat_sum = s[DataW+1] ? Q_MIN : Q_MAX;
    end
  endfunction

  // floor shift of a full product back to q8.24, then saturate
  function automatic q_t sat_prod(input qprod_t p);
    logic [2*DataW-1-FracW:DataW-1] top;
    top = p[2*DataW-1:DataW-1+FracW];
    if (&top || ~|top) begin
      sat_prod = p[DataW-1+FracW:FracW];
    end else begin
      sat_prod = p[2*DataW-1] ? Q_MIN : Q_MAX;
    end
  endfunction

endpackage

>>> design/pid_regulator_antiwindup.sv
// pid_regulator_antiwindup: series pid with setpoint weighting, filtered
// derivative, output clamp and clamp-based anti-windup
// depends on pidaw_pkg (types, register indexes, saturation helpers)

// Usage
//   input channel: in_valid_i / in_ready_o carry one reference and one feedback
//   sample per transfer. output channel: out_valid_o / out_ready_i carry drive,
//   clamped and the running absolute error sum, one result per input transfer.
//   configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   always ready, write only between samples.
// Timing
//   every product goes through one shared 32x32 multiplier with a registered
//   product, sums and differences use small saturating adders, stepped by a
//   12-state one-hot sequencer (idle plus 11 steps). the result is registered
//   in the clamp step, and the next sample is taken only once the sequencer
//   is back in idle.
//   in_ready_o is high whenever the sequencer is idle, also while a result
//   is still waiting in the output register.
// Reset
//   gains and limits go to their defaults (kr = km = 1.0, full-range limits),
//   integrator, derivative memories and error sum go to zero, integration on.
// Stall
//   if the receiver has not taken the previous result, the sequencer holds
//   in its last step until the output register frees up; no result is lost.

module pid_regulator_antiwindup
  import pidaw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   reference_i,
  input  logic signed [31:0]   feedback_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   drive_o,
  output logic                 clamped_o,
  output logic [46:0]          abs_error_total_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // one-hot sequencer, one step per cycle, holding in the clamp step while the output register is full
  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_MKR   = 12'b0000_0000_0010, // product kr * reference
    ST_MKI   = 12'b0000_0000_0100, // proportional term, product ki * error
    ST_MKM   = 12'b0000_0000_1000, // integrator update, product km * reference
    ST_TD    = 12'b0000_0001_0000, // weighted derivative input
    ST_MKD   = 12'b0000_0010_0000, // product kd_c1 * derivative input
    ST_D2    = 12'b0000_0100_0000, // difference against previous input
    ST_UD    = 12'b0000_1000_0000, // add filter memory
    ST_MC2   = 12'b0001_0000_0000, // product c2 * derivative term
    ST_SUM   = 12'b0010_0000_0000, // filter memory update, sum of terms
    ST_MKP   = 12'b0100_0000_0000, // product kp * sum
    ST_CLAMP = 12'b1000_0000_0000  // clamp and load the output register
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  q_t kp_q, ki_q, kd_c1_q, kr_q, km_q, c2_q, umax_q, umin_q;

  // controller state
  q_t   integ_q;
  q_t   fmem_q;
  q_t   prev_q;
  logic integ_en_q;
  acc_t acc_q;

  // per-sample working registers
  q_t     ref_q, fbk_q, err_q, up_q, ud_q, tmp_q;
  qprod_t prod_q;

  // output register
  logic out_valid_q;
  q_t   drive_q;
  logic clamped_q;
  acc_t abs_q;

  logic in_fire;
  logic out_load;
  logic mul_en;
  q_t   mul_a, mul_b;
  q_t   mq;       // product shifted back to q8.24, saturated
  q_t   v_clamp;
  logic v_clip;
  logic [31:0] abs_err;
  logic [AccW:0] acc_sum;
  acc_t acc_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  // result can go out once the output register is free or being emptied
  assign out_load    = (state_q == ST_CLAMP) & (~out_valid_q | out_ready_i);

  assign mq = sat_prod(prod_q);

  // shared multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = kp_q;
    mul_b  = tmp_q;
    case (state_q)
      ST_MKR: begin
        mul_a = kr_q;
        mul_b = ref_q;
      end
      ST_MKI: begin
        mul_a = ki_q;
        mul_b = err_q;
      end
      ST_MKM: begin
        mul_a = km_q;
        mul_b = ref_q;
      end
      ST_MKD: begin
        mul_a = kd_c1_q;
        mul_b = tmp_q;
      end
      ST_MC2: begin
        mul_a = c2_q;
        mul_b = ud_q;
      end
      ST_MKP: begin
        mul_a = kp_q;
        mul_b = tmp_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // clamp, upper limit tested first: with inverted limits a value above umax resolves to umax, any other to umin
  always_comb begin
    if (mq > umax_q) begin
      v_clamp = umax_q;
    end else if (mq < umin_q) begin
      v_clamp = umin_q;
    end else begin
      v_clamp = mq;
    end
    v_clip = (v_clamp != mq);
  end

  // absolute error, the most negative error maps to 2^31 exactly
  assign abs_err = err_q[31] ? (~err_q + 32'd1) : err_q;
  assign acc_sum = {1'b0, acc_q} + (AccW+1)'(abs_err);
  assign acc_d   = acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) begin
        state_d = ST_MKR;
      end
      ST_MKR:   state_d = ST_MKI;
      ST_MKI:   state_d = ST_MKM;
      ST_MKM:   state_d = ST_TD;
      ST_TD:    state_d = ST_MKD;
      ST_MKD:   state_d = ST_D2;
      ST_D2:    state_d = ST_UD;
      ST_UD:    state_d = ST_MC2;
      ST_MC2:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_MKP;
      ST_MKP:   state_d = ST_CLAMP;
      ST_CLAMP: if (out_load) begin
        state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_c1_q     <= '0;
      kr_q        <= Q_ONE;
      km_q        <= Q_ONE;
      c2_q        <= '0;
      umax_q      <= Q_MAX;
      umin_q      <= Q_MIN;
      integ_q     <= '0;
      fmem_q      <= '0;
      prev_q      <= '0;
      integ_en_q  <= 1'b1;
      acc_q       <= '0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_KP:    kp_q    <= cfg_data_i;
          CFG_KI:    ki_q    <= cfg_data_i;
          CFG_KD_C1: kd_c1_q <= cfg_data_i;
          CFG_KR:    kr_q    <= cfg_data_i;
          CFG_KM:    km_q    <= cfg_data_i;
          CFG_C2:    c2_q    <= cfg_data_i;
          CFG_UMAX:  umax_q  <= cfg_data_i;
          CFG_UMIN:  umin_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_MKR) begin
        acc_q <= acc_d;
      end
      // integrator frozen on a sample that follows a clamped output
      if (state_q == ST_MKM && integ_en_q) begin
        integ_q <= sat_sum(ext_sum(mq) + ext_sum(integ_q));
      end
      if (state_q == ST_D2) begin
        prev_q <= mq;
      end
      if (state_q == ST_SUM) begin
        fmem_q <= mq;
      end
      if (out_load) begin
        integ_en_q <= ~v_clip;
      end
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (in_fire) begin
      ref_q <= reference_i;
      fbk_q <= feedback_i;
      err_q <= sat_sum(ext_sum(reference_i) - ext_sum(feedback_i));
    end
    case (state_q)
      ST_MKI: up_q  <= sat_sum(ext_sum(mq) - ext_sum(fbk_q));
      ST_TD:  tmp_q <= sat_sum(ext_sum(mq) - ext_sum(fbk_q));
      ST_D2:  tmp_q <= sat_sum(ext_sum(mq) - ext_sum(prev_q));
      ST_UD:  ud_q  <= sat_sum(ext_sum(tmp_q) + ext_sum(fmem_q));
      ST_SUM: tmp_q <= sat_sum(ext_sum(up_q) + ext_sum(integ_q) + ext_sum(ud_q));
      default: ;
    endcase
    if (out_load) begin
      drive_q   <= v_clamp;
      clamped_q <= v_clip;
      abs_q     <= acc_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_o           = drive_q;
  assign clamped_o         = clamped_q;
  assign abs_error_total_o = abs_q;

  // sequencer stays one-hot
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // a clamped result always sits on one of the limits
  a_clamp_on_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clamped_o) |-> (drive_o == umax_q || drive_o == umin_q))
    else $error("clamped drive is not at a limit");

  // integration enable follows the clamp flag of the result just loaded
  a_antiwindup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (integ_en_q != clamped_q))
    else $error("integrate enable does not follow clamp flag");

  // a pending result is never overwritten before its transfer
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP && out_valid_q && !out_ready_i) |=> (state_q == ST_CLAMP))
    else $error("sequencer left its last step with output still pending");

endmodule
